// File: hdl/text_console_terminal_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef TEXT_CONSOLE_TERMINAL_UNIT_MACROS_SVH
`define TEXT_CONSOLE_TERMINAL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCTU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("text console terminal check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCTU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("text console terminal check failed");

`endif

// File: hdl/tcon_pkg.sv
package tcon_pkg;

  // Screen geometry.
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TAB_STEP      = 8;
  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  // Field widths of the words on the ports.
  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int OFFSET_W = 11;
  localparam int CELL_W   = 16;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 3'd0,
    ACT_GOTO   = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_COLOUR = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  // Next tab stop for every possible column, worked out at elaboration.
  typedef logic [COL_W:0] tab_table_t [2**COL_W];

  function automatic tab_table_t build_tab_table();
    tab_table_t t;
    for (int i = 0; i < 2**COL_W; i++) begin
      t[i] = (COL_W+1)'(i - (i % TAB_STEP) + TAB_STEP);
    end
    return t;
  endfunction

  localparam tab_table_t TAB_NEXT = build_tab_table();

endpackage

// File: hdl/tcon_ram.sv
module tcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/text_console_terminal_unit.sv
// Text-mode terminal over a screen of ROWS lines of COLUMNS cells (80x25), each cell a
// 16-bit word with the attribute byte above the character byte. Every accepted word
// performs one action (write a character, go to a position, clear the screen in a new
// colour, set the colour, read a cell) and yields exactly one result word carrying the
// cursor, its linear offset and the data. The screen lives in one single-port-write,
// registered-read memory, and that one write port sets the pace: no new word is taken
// until the last one has placed its result in the output register. Writing a character,
// moving the cursor, setting the colour or reading a cell goes straight to that step;
// clearing the screen first fills every cell with blanks; a character that makes the
// screen scroll first copies the screen up, one cell per cycle, then blanks the bottom
// line. After reset the block runs a clearing pass over every cell, with in_ready_o low.
module text_console_terminal_unit
  import tcon_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CHAR_W-1:0]   value_i,
  input  logic [COL_W-1:0]    col_i,
  input  logic [ROW_W-1:0]    row_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COL_W-1:0]    cursor_col_o,
  output logic [ROW_W-1:0]    cursor_row_o,
  output logic [OFFSET_W-1:0] cursor_offset_o,
  output logic [CELL_W-1:0]   data_o
);

  // Control state.
  state_e              state_q, state_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [CHAR_W-1:0]   colour_q, colour_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic                rd_pend_q, rd_pend_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers.
  logic [CELL_W-1:0]   data_q, data_d;
  logic [COL_W-1:0]    out_col_q, out_col_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;
  logic [OFFSET_W-1:0] out_offset_q, out_offset_d;
  logic [CELL_W-1:0]   out_data_q, out_data_d;

  // Screen memory ports.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   tgt_addr;
  logic [CELL_W-1:0]   blank_word;
  logic [COL_W:0]      nxt_col;
  logic [ROW_W:0]      nxt_row;
  logic                tgt_col_ok;
  logic                tgt_row_ok;

  // Linear addresses of the cursor and of the requested position.
  assign cur_addr   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign tgt_addr   = ADDR_W'(row_i) * ADDR_W'(COLUMNS) + ADDR_W'(col_i);
  assign tgt_col_ok = {1'b0, col_i} < (COL_W+1)'(COLUMNS);
  assign tgt_row_ok = {1'b0, row_i} < (ROW_W+1)'(ROWS);

  // A blank in the current colour; also the reset pattern, as the colour resets to zero.
  assign blank_word = {colour_q, CH_BLANK};

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    colour_d     = colour_q;
    cnt_d        = cnt_q;
    rd_pend_d    = rd_pend_q;
    data_d       = data_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_offset_d = out_offset_q;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q;
    ram_wdata    = blank_word;
    ram_re       = 1'b0;
    ram_raddr    = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
    nxt_col      = {1'b0, col_q};
    nxt_row      = {1'b0, row_q};

    unique case (state_q)
      ST_INIT: begin
        // Clearing pass after reset: one cell per cycle.
        ram_we = 1'b1;
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          data_d    = '0;
          rd_pend_d = 1'b0;
          state_d   = ST_DONE;
          unique case (action_e'(action_i))
            ACT_WRITE: begin
              if (value_i == CH_BS) begin
                if (col_q != '0) begin
                  nxt_col = {1'b0, col_q} - 1'b1;
                end
              end else if (value_i == CH_TAB) begin
                nxt_col = TAB_NEXT[col_q];
              end else if (value_i == CH_CR) begin
                nxt_col = '0;
              end else if (value_i == CH_LF) begin
                nxt_col = '0;
                nxt_row = {1'b0, row_q} + 1'b1;
              end else if (value_i >= CH_BLANK) begin
                // Printable: store it at the cursor in the current colour.
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {colour_q, value_i};
                nxt_col   = {1'b0, col_q} + 1'b1;
              end
              // Wrap at the end of the line.
              if (nxt_col >= (COL_W+1)'(COLUMNS)) begin
                nxt_col = '0;
                nxt_row = nxt_row + 1'b1;
              end
              // Past the bottom line: scroll the whole screen up by one line.
              if (nxt_row >= (ROW_W+1)'(ROWS)) begin
                nxt_row = (ROW_W+1)'(ROWS - 1);
                cnt_d   = '0;
                state_d = ST_SCROLL;
              end
              col_d = COL_W'(nxt_col);
              row_d = ROW_W'(nxt_row);
            end
            ACT_GOTO: begin
              // Each coordinate is taken on its own, and only when in range.
              if (tgt_col_ok) begin
                col_d = col_i;
              end
              if (tgt_row_ok) begin
                row_d = row_i;
              end
            end
            ACT_CLEAR: begin
              colour_d = value_i;
              col_d    = '0;
              row_d    = '0;
              cnt_d    = '0;
              state_d  = ST_FILL;
            end
            ACT_COLOUR: begin
              data_d   = {{(CELL_W-CHAR_W){1'b0}}, colour_q};
              colour_d = value_i;
            end
            ACT_READ: begin
              if (tgt_col_ok && tgt_row_ok) begin
                ram_re    = 1'b1;
                ram_raddr = tgt_addr;
                rd_pend_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // Cell k+COLUMNS is read in one cycle and written to cell k in the next,
        // so the write always trails the read and never overtakes it.
        if (cnt_q != ADDR_W'(LAST_ROW_BASE)) begin
          ram_re = 1'b1;
        end
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt_q == ADDR_W'(LAST_ROW_BASE)) begin
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_FILL: begin
        // Blanks in the current colour from cnt_q up to the last cell.
        ram_we = 1'b1;
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_DONE: begin
        // The output register is normally free here; wait if it is not.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_col_d    = col_q;
          out_row_d    = row_q;
          out_offset_d = OFFSET_W'(cur_addr);
          out_data_d   = rd_pend_q ? ram_rdata : data_q;
          rd_pend_d    = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      colour_q    <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      colour_q    <= colour_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    out_col_q    <= out_col_d;
    out_row_q    <= out_row_d;
    out_offset_q <= out_offset_d;
    out_data_q   <= out_data_d;
  end

  tcon_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_offset_o = out_offset_q;
  assign data_o          = out_data_q;

endmodule

// File: hdl/tcon_checker.sv
`include "text_console_terminal_unit_macros.svh"

module tcon_checker
  import tcon_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [COL_W-1:0]    cursor_col_o,
  input logic [ROW_W-1:0]    cursor_row_o,
  input logic [OFFSET_W-1:0] cursor_offset_o,
  input logic [CELL_W-1:0]   data_o
);

  logic [OFFSET_W-1:0] exp_offset;
  logic                cursor_ok;

  assign exp_offset = OFFSET_W'(32'(cursor_row_o) * COLUMNS + 32'(cursor_col_o));
  assign cursor_ok  = (32'(cursor_col_o) < COLUMNS) && (32'(cursor_row_o) < ROWS);

  `TCTU_ASSERT_SAME(a_cursor_in_screen, clk_i, rst_ni, out_valid_o, cursor_ok)
  `TCTU_ASSERT_SAME(a_offset_matches, clk_i, rst_ni, out_valid_o, (cursor_offset_o == exp_offset))
  `TCTU_ASSERT_NEXT(a_one_word_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o), !in_ready_o)
  `TCTU_ASSERT_NEXT(a_result_held, clk_i, rst_ni, (out_valid_o && !out_ready_i),
                    (out_valid_o && $stable(data_o) && $stable(cursor_offset_o)))

endmodule

bind text_console_terminal_unit tcon_checker u_tcon_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .cursor_col_o    (cursor_col_o),
  .cursor_row_o    (cursor_row_o),
  .cursor_offset_o (cursor_offset_o),
  .data_o          (data_o)
);

// File: tb/sv/tb_top.sv
module tb_top;
  import tcon_pkg::*;

  // Timing of the run. The limit allows for the clearing pass after reset and for every
  // word making the screen scroll, with the stalls on both sides, several times over.
  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int TAIL_CYCLES    = 16;
  localparam int PHASE_WORDS    = 100;

  // Action codes above ACT_READ have no meaning and must leave the terminal untouched.
  localparam int ACT_LAST = 2**ACTION_W - 1;

  // Control bytes that move the cursor without storing anything.
  localparam logic [CHAR_W-1:0] CONTROL_CODES [4] = '{CH_BS, CH_TAB, CH_CR, CH_LF};

  // One command word as it is offered on the input channel.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   value;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } terminal_word_t;

  // One result word: the cursor after the action and the data that it returned.
  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [OFFSET_W-1:0] offset;
    logic [CELL_W-1:0]   data;
  } cursor_report_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i   = ACT_WRITE;
  logic [CHAR_W-1:0]   value_i    = '0;
  logic [COL_W-1:0]    col_i      = '0;
  logic [ROW_W-1:0]    row_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [COL_W-1:0]    cursor_col_o;
  logic [ROW_W-1:0]    cursor_row_o;
  logic [OFFSET_W-1:0] cursor_offset_o;
  logic [CELL_W-1:0]   data_o;

  text_console_terminal_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .value_i         (value_i),
    .col_i           (col_i),
    .row_i           (row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_offset_o (cursor_offset_o),
    .data_o          (data_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Words still to be offered, and the results that accepted words have yet to produce.
  terminal_word_t pending_words [$];
  cursor_report_t expected_reports [$];

  // Percentage of cycles in which each side holds back.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Our own copy of the screen, the cursor and the colour.
  logic [CELL_W-1:0] model_cells [CELL_COUNT];
  int unsigned       model_col;
  int unsigned       model_row;
  logic [CHAR_W-1:0] model_colour;

  int unsigned words_accepted  = 0;
  int unsigned reports_checked = 0;
  int unsigned scroll_count    = 0;
  int unsigned clear_count     = 0;
  int unsigned fault_count     = 0;

  // Fills every cell from the given index to the end of the screen.
  function automatic void fill_cells(int first, logic [CELL_W-1:0] word);
    for (int k = first; k < CELL_COUNT; k++) begin
      model_cells[k] = word;
    end
  endfunction

  // Applies one accepted word to our copy of the terminal and returns the result that
  // the block has to give for it.
  function automatic cursor_report_t apply_terminal_word(terminal_word_t w);
    cursor_report_t r;
    logic [CELL_W-1:0] data;
    data = '0;
    case (w.action)
      ACT_WRITE: begin
        if (w.value == CH_BS) begin
          // Backspace at the left margin does nothing.
          if (model_col > 0) model_col--;
        end else if (w.value == CH_TAB) begin
          model_col = model_col - model_col % TAB_STEP + TAB_STEP;
        end else if (w.value == CH_CR) begin
          model_col = 0;
        end else if (w.value == CH_LF) begin
          model_col = 0;
          model_row++;
        end else if (w.value >= CH_BLANK) begin
          model_cells[model_row * COLUMNS + model_col] = {model_colour, w.value};
          model_col++;
        end
        // Running off the right edge wraps to the next line; running off the bottom
        // moves every line up by one and blanks the bottom line in the current colour.
        if (model_col >= COLUMNS) begin
          model_col = 0;
          model_row++;
        end
        if (model_row >= ROWS) begin
          for (int k = 0; k < LAST_ROW_BASE; k++) begin
            model_cells[k] = model_cells[k + COLUMNS];
          end
          fill_cells(LAST_ROW_BASE, {model_colour, CH_BLANK});
          model_row = ROWS - 1;
          scroll_count++;
        end
      end
      ACT_GOTO: begin
        // Each coordinate is taken on its own, and only when it lies on the screen.
        if (w.col < COLUMNS) model_col = w.col;
        if (w.row < ROWS) model_row = w.row;
      end
      ACT_CLEAR: begin
        model_colour = w.value;
        fill_cells(0, {w.value, CH_BLANK});
        model_col = 0;
        model_row = 0;
        clear_count++;
      end
      ACT_COLOUR: begin
        data = CELL_W'(model_colour);
        model_colour = w.value;
      end
      ACT_READ: begin
        if (w.col < COLUMNS && w.row < ROWS) data = model_cells[w.row * COLUMNS + w.col];
      end
      default: begin
      end
    endcase
    r.col    = COL_W'(model_col);
    r.row    = ROW_W'(model_row);
    r.offset = OFFSET_W'(model_row * COLUMNS + model_col);
    r.data   = data;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fault_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic push_word(input int unsigned action, input int unsigned value,
                           input int unsigned col, input int unsigned row);
    terminal_word_t w;
    w.action = ACTION_W'(action);
    w.value  = CHAR_W'(value);
    w.col    = COL_W'(col);
    w.row    = ROW_W'(row);
    pending_words.push_back(w);
  endtask

  // Adds about n random words. Most of them come as lines of text: a jump to a position,
  // often near the bottom so that the screen scrolls, a run of characters with a few
  // control bytes among them, and now and then a read-back of the cells just written.
  // Single words of every action, with fields over their whole range, fill the rest.
  task automatic queue_random_words(input int n);
    int unsigned start;
    int unsigned pick;
    int unsigned c;
    int unsigned r;
    int unsigned len;
    int unsigned ch;
    start = pending_words.size();
    while (pending_words.size() - start < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        c = $urandom_range(COLUMNS - 1);
        r = $urandom_range(1) ? $urandom_range(ROWS - 1, ROWS - 5) : $urandom_range(ROWS - 1);
        push_word(ACT_GOTO, $urandom, c, r);
        len = $urandom_range(20, 3);
        for (int i = 0; i < len; i++) begin
          ch = $urandom_range(99);
          if (ch < 85) begin
            ch = $urandom_range(2**CHAR_W - 1, CH_BLANK);
          end else if (ch < 95) begin
            ch = CONTROL_CODES[$urandom_range(3)];
          end else begin
            ch = $urandom_range(CH_BLANK - 1);
          end
          push_word(ACT_WRITE, ch, $urandom, $urandom);
        end
        if ($urandom_range(1)) begin
          for (int i = 0; i < len && i < 4; i++) begin
            push_word(ACT_READ, $urandom, c + i, r);
          end
        end
      end else if (pick < 50) begin
        push_word(ACT_WRITE, $urandom, $urandom, $urandom);
      end else if (pick < 65) begin
        push_word(ACT_GOTO, $urandom, $urandom, $urandom);
      end else if (pick < 80) begin
        push_word(ACT_READ, $urandom, $urandom, $urandom);
      end else if (pick < 90) begin
        push_word(ACT_COLOUR, $urandom, $urandom, $urandom);
      end else if (pick < 94) begin
        push_word(ACT_CLEAR, $urandom, $urandom, $urandom);
      end else begin
        push_word($urandom_range(ACT_LAST, ACT_READ + 1), $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_until_quiet();
    while (pending_words.size() != 0 || in_valid_i || expected_reports.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver. A word that has been accepted is applied to our copy of the terminal at the
  // very edge that took it; a new word is then offered unless the sender idles. Valid is
  // given exactly one value per edge so that it never dips between two back-to-back words.
  always @(posedge clk_i) begin : drive_words
    terminal_word_t next_word;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_reports.push_back(apply_terminal_word({action_i, value_i, col_i, row_i}));
        words_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          action_i   <= next_word.action;
          value_i    <= next_word.value;
          col_i      <= next_word.col;
          row_i      <= next_word.row;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result taken from the block is held against the oldest expectation,
  // field by field; a result that nobody asked for is a failure in its own right.
  always @(posedge clk_i) begin : watch_reports
    cursor_report_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("result word with no command word outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("cursor_col", cursor_col_o, want.col);
          check_field("cursor_row", cursor_row_o, want.row);
          check_field("cursor_offset", cursor_offset_o, want.offset);
          check_field("data", data_o, want.data);
          reports_checked++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    // Asserted after every process has started, so that the block sees the falling edge.
    rst_ni <= 1'b0;
    fill_cells(0, CELL_W'(CH_BLANK));
    model_col    = 0;
    model_row    = 0;
    model_colour = '0;

    // Directed opening: a read of the freshly cleared screen, the colour swap at both
    // extremes, every control byte including backspace at the left margin, ignored
    // control bytes, jumps with one, both or neither coordinate off the screen, scrolling
    // by a wrapped character, by a tab past the last column and by a line feed on the
    // bottom row, reads of the last cell and of a cell off the screen, a clear, and the
    // unused action codes.
    push_word(ACT_READ, 0, 0, 0);
    push_word(ACT_COLOUR, 8'hFF, 0, 0);
    push_word(ACT_WRITE, 8'h41, 0, 0);
    push_word(ACT_READ, 0, 0, 0);
    push_word(ACT_WRITE, 8'hFF, 0, 0);
    push_word(ACT_WRITE, CH_BS, 0, 0);
    push_word(ACT_WRITE, CH_BS, 0, 0);
    push_word(ACT_WRITE, CH_BS, 0, 0);
    push_word(ACT_WRITE, CH_TAB, 0, 0);
    push_word(ACT_WRITE, 8'h00, 0, 0);
    push_word(ACT_WRITE, CH_BLANK - 1, 0, 0);
    push_word(ACT_WRITE, CH_BLANK, 0, 0);
    push_word(ACT_WRITE, CH_CR, 0, 0);
    push_word(ACT_WRITE, CH_LF, 0, 0);
    push_word(ACT_GOTO, 0, 2**COL_W - 1, 2**ROW_W - 1);
    push_word(ACT_GOTO, 0, COLUMNS - 1, ROWS);
    push_word(ACT_GOTO, 0, COLUMNS, ROWS - 1);
    push_word(ACT_WRITE, 8'h7E, 0, 0);
    push_word(ACT_GOTO, 0, COLUMNS - 4, ROWS - 1);
    push_word(ACT_WRITE, CH_TAB, 0, 0);
    push_word(ACT_WRITE, CH_LF, 0, 0);
    push_word(ACT_READ, 0, COLUMNS - 1, ROWS - 1);
    push_word(ACT_READ, 0, 2**COL_W - 1, 2**ROW_W - 1);
    push_word(ACT_CLEAR, 8'h5A, 0, 0);
    for (int a = ACT_READ + 1; a <= ACT_LAST; a++) begin
      push_word(a, 8'hFF, 2**COL_W - 1, 2**ROW_W - 1);
    end

    // First phase: the sender idles lightly, the receiver heavily.
    send_idle_pct = 29;
    recv_idle_pct = 63;
    queue_random_words(PHASE_WORDS);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_until_quiet();

    // Second phase with the idling the other way round, then a phase at full rate.
    send_idle_pct = 63;
    recv_idle_pct = 29;
    queue_random_words(PHASE_WORDS);
    wait_until_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_words(PHASE_WORDS);
    wait_until_quiet();

    // Give a stray result time to show itself.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d command words and %0d result words", words_accepted,
             reports_checked);
    $display("the screen scrolled %0d times and was cleared %0d times", scroll_count,
             clear_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d words unsent and %0d results outstanding",
             pending_words.size(), expected_reports.size());
    $display("status: fail");
    $finish;
  end

endmodule
